// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the space vector PWM block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER_CLK(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER_CLK(lbl, clk, rst, cond)
`endif
`endif

// File: src/svpwm_pkg.sv
// Shared types and constants for the space vector PWM compare block.
// No dependencies; used by svpwm_scale, svpwm_dwell and the top level.
`default_nettype none

package svpwm_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int IN_W          = 24;
  localparam int VEC_W         = IN_W + 1;
  localparam int DUTY_W        = 16;
  localparam int TW            = (FRACTION_BITS > 11) ? FRACTION_BITS + 19 : 30;

  localparam logic [IN_W-1:0]   INV_SQRT3_Q24 = 24'd9686330;
  localparam logic [DUTY_W-1:0] PERIOD_RESET  = 16'd4096;

  localparam int        PADDR_W      = 3;
  localparam logic      ADDR_PERIOD  = 1'b0;

  typedef enum logic [2:0] {
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_t;

  // Negated vector with beta already scaled by 1/sqrt(3)
  typedef struct packed {
    logic [VEC_W-1:0] a;
    logic [VEC_W-1:0] m;
    logic             b_neg;
  } svpwm_vec_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    sector_t           sector;
  } svpwm_res_t;

endpackage

`default_nettype wire

// File: src/svpwm_scale.sv
// Front stage logic: negate the input vector and scale beta by 1/sqrt(3).
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_scale (
  input  wire logic signed [svpwm_pkg::IN_W-1:0] volt_alpha,
  input  wire logic signed [svpwm_pkg::IN_W-1:0] volt_beta,
  output svpwm_pkg::svpwm_vec_t                  vec
);

  logic signed [svpwm_pkg::VEC_W-1:0]   a;
  logic signed [svpwm_pkg::VEC_W-1:0]   b;
  logic        [svpwm_pkg::VEC_W-1:0]   b_mag;
  logic        [2*svpwm_pkg::IN_W-1:0]  prod;
  logic        [svpwm_pkg::VEC_W-1:0]   q;

  always_comb begin
    a     = -$signed({volt_alpha[svpwm_pkg::IN_W-1], volt_alpha});
    b     = -$signed({volt_beta[svpwm_pkg::IN_W-1], volt_beta});
    // Magnitude is at most 2^23, so it fits the low IN_W bits
    b_mag = b[svpwm_pkg::VEC_W-1] ? -b : b;
    prod  = b_mag[svpwm_pkg::IN_W-1:0] * svpwm_pkg::INV_SQRT3_Q24;
    q     = {1'b0, prod[2*svpwm_pkg::IN_W-1:svpwm_pkg::IN_W]};
    vec.a     = a;
    vec.m     = b[svpwm_pkg::VEC_W-1] ? -q : q;
    vec.b_neg = b[svpwm_pkg::VEC_W-1];
  end

endmodule

`default_nettype wire

// File: src/svpwm_dwell.sv
// Back stage logic: sector decision, dwell times and clamped compare values.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_dwell (
  input  wire svpwm_pkg::svpwm_vec_t           vec,
  input  wire logic [svpwm_pkg::DUTY_W-1:0]    pwm_period,
  output svpwm_pkg::svpwm_res_t                res
);

  localparam int TW = svpwm_pkg::TW;
  localparam int VW = svpwm_pkg::VEC_W;

  logic signed [VW-1:0] a;
  logic signed [VW-1:0] m;
  logic signed [VW-1:0] neg_m;
  logic signed [TW-1:0] aw;
  logic signed [TW-1:0] mw;
  logic signed [TW-1:0] p2;
  logic signed [TW-1:0] tx;
  logic signed [TW-1:0] ty;
  logic signed [TW-1:0] t_first;
  logic signed [TW-1:0] t_second;
  logic signed [TW-1:0] t_third;
  logic signed [TW-1:0] ta;
  logic signed [TW-1:0] tb;
  logic signed [TW-1:0] tc;
  svpwm_pkg::sector_t   sec;

  // Drop the doubling and fraction bits, then clamp to 0..period
  function automatic logic [svpwm_pkg::DUTY_W-1:0] to_compare(
    input logic signed [TW-1:0]             v,
    input logic [svpwm_pkg::DUTY_W-1:0]     per
  );
    logic [TW-1:0] q;
    q = v >> (svpwm_pkg::FRACTION_BITS + 1);
    if (v[TW-1] || (v == {TW{1'b0}})) begin
      return {svpwm_pkg::DUTY_W{1'b0}};
    end else if (q > {{(TW-svpwm_pkg::DUTY_W){1'b0}}, per}) begin
      return per;
    end else begin
      return q[svpwm_pkg::DUTY_W-1:0];
    end
  endfunction

  always_comb begin
    a     = $signed(vec.a);
    m     = $signed(vec.m);
    neg_m = -m;
    aw    = {{(TW-VW){a[VW-1]}}, a};
    mw    = {{(TW-VW){m[VW-1]}}, m};
    p2    = $signed({{(TW-svpwm_pkg::DUTY_W-svpwm_pkg::FRACTION_BITS){1'b0}},
                     pwm_period, {svpwm_pkg::FRACTION_BITS{1'b0}}});

    if (!vec.b_neg) begin
      if (!a[VW-1]) sec = (m > a) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
      else          sec = (neg_m > a) ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_2;
    end else begin
      if (!a[VW-1]) sec = (neg_m > a) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_6;
      else          sec = (m > a) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_5;
    end

    unique case (sec)
      svpwm_pkg::SECTOR_1: begin tx = aw - mw;  ty = mw <<< 1;   end
      svpwm_pkg::SECTOR_2: begin tx = aw + mw;  ty = mw - aw;    end
      svpwm_pkg::SECTOR_3: begin tx = mw <<< 1; ty = -aw - mw;   end
      svpwm_pkg::SECTOR_4: begin tx = mw - aw;  ty = -(mw <<< 1); end
      svpwm_pkg::SECTOR_5: begin tx = -aw - mw; ty = aw - mw;    end
      default:             begin tx = -(mw <<< 1); ty = aw + mw; end
    endcase

    // Odd sectors add tx first, even sectors add ty first
    t_first = p2 - tx - ty;
    if (sec == svpwm_pkg::SECTOR_1 || sec == svpwm_pkg::SECTOR_3 ||
        sec == svpwm_pkg::SECTOR_5) begin
      t_second = t_first + (tx <<< 1);
      t_third  = t_second + (ty <<< 1);
    end else begin
      t_second = t_first + (ty <<< 1);
      t_third  = t_second + (tx <<< 1);
    end

    unique case (sec)
      svpwm_pkg::SECTOR_1: begin ta = t_first;  tb = t_second; tc = t_third;  end
      svpwm_pkg::SECTOR_2: begin tb = t_first;  ta = t_second; tc = t_third;  end
      svpwm_pkg::SECTOR_3: begin tb = t_first;  tc = t_second; ta = t_third;  end
      svpwm_pkg::SECTOR_4: begin tc = t_first;  tb = t_second; ta = t_third;  end
      svpwm_pkg::SECTOR_5: begin tc = t_first;  ta = t_second; tb = t_third;  end
      default:             begin ta = t_first;  tc = t_second; tb = t_third;  end
    endcase

    res.duty_a = to_compare(ta, pwm_period);
    res.duty_b = to_compare(tb, pwm_period);
    res.duty_c = to_compare(tc, pwm_period);
    res.sector = sec;
  end

endmodule

`default_nettype wire

// File: src/space_vector_pwm_compare.sv
// Top level of the space vector PWM compare block: handshake, pipeline
// registers and APB register. Depends on svpwm_pkg, svpwm_scale, svpwm_dwell
// and assert_macros.svh.
//
//   channel   direction   handshake              payload
//   input     in          in_valid / in_ready    volt_alpha, volt_beta
//   output    out         out_valid / out_ready  duty_a, duty_b, duty_c, sector
//   config    in (APB)    psel/penable/pready    paddr, pwdata, prdata
//
// One transaction is accepted per cycle while in_ready is high; the vector
// register holds it after the negate and 24x24 multiply, then the result
// register after the sector/dwell logic.
// Reset (rst, synchronous, active high) empties both stages and loads the
// period register with 4096; there is no clearing pass.
// A stalled output holds the result register; the vector stage accepts while
// it is empty or the result register is free or being taken this cycle, so a
// stall stops the input only once both stages are full.
`default_nettype none
`include "assert_macros.svh"

module space_vector_pwm_compare (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [svpwm_pkg::IN_W-1:0]   volt_alpha,
  input  wire logic signed [svpwm_pkg::IN_W-1:0]   volt_beta,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [svpwm_pkg::DUTY_W-1:0]             duty_a,
  output logic [svpwm_pkg::DUTY_W-1:0]             duty_b,
  output logic [svpwm_pkg::DUTY_W-1:0]             duty_c,
  output logic [2:0]                               sector,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [svpwm_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic [svpwm_pkg::DUTY_W-1:0] pwm_period;
  logic                         s1_valid;
  svpwm_pkg::svpwm_vec_t        s1_vec;
  svpwm_pkg::svpwm_vec_t        vec_next;
  svpwm_pkg::svpwm_res_t        res_next;
  svpwm_pkg::svpwm_res_t        res;
  logic                         out_free;
  logic                         cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration: single period register at byte addresses 0 to 3. Byte
  // addresses 4 to 7 read as zero and ignore writes.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[svpwm_pkg::PADDR_W-1] == svpwm_pkg::ADDR_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= svpwm_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      pwm_period <= pwdata[svpwm_pkg::DUTY_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[svpwm_pkg::PADDR_W-1] == svpwm_pkg::ADDR_PERIOD) begin
      prdata = {{(32-svpwm_pkg::DUTY_W){1'b0}}, pwm_period};
    end
  end

  // ---------------------------------------------------------------------
  // Datapath: negate and scale, register, then sector and compares.
  // ---------------------------------------------------------------------
  svpwm_scale u_scale (
    .volt_alpha (volt_alpha),
    .volt_beta  (volt_beta),
    .vec        (vec_next)
  );

  svpwm_dwell u_dwell (
    .vec        (s1_vec),
    .pwm_period (pwm_period),
    .res        (res_next)
  );

  // Result register is free when empty or being drained this cycle;
  // the vector stage may then refill as well.
  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid  <= in_valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  // Payload registers: load only on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_vec <= vec_next;
    if (s1_valid && out_free) res    <= res_next;
  end

  assign duty_a = res.duty_a;
  assign duty_b = res.duty_b;
  assign duty_c = res.duty_c;
  assign sector = res.sector;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Accepted transaction always lands in the vector stage
  `ASSERT_CLK(a_in_to_s1, clk, rst, (in_valid && in_ready) |=> s1_valid)
  // A blocked vector stage keeps its contents
  `ASSERT_CLK(a_s1_hold, clk, rst,
              (s1_valid && !out_free) |=> (s1_valid && $stable(s1_vec)))
  // Draining with nothing behind empties the output
  `ASSERT_CLK(a_drain, clk, rst,
              (out_valid && out_ready && !s1_valid) |=> !out_valid)
  // Clamp keeps every compare within the period
  `ASSERT_NEVER_CLK(a_clamp, clk, rst,
                    out_valid && (duty_a > pwm_period || duty_b > pwm_period ||
                                  duty_c > pwm_period))

endmodule

`default_nettype wire

// File: sim/tb_space_vector_pwm_compare.sv
`timescale 1ns / 100ps
// Self-checking testbench for space_vector_pwm_compare: streams voltage vectors
// through the valid/ready input and checks every compare set against its own
// predictor. Depends on svpwm_pkg and the RTL of the block only.

module tb_space_vector_pwm_compare;
  import svpwm_pkg::*;

  // Register indexes of the APB map; byte address is 4 * index
  localparam int PERIOD_INDEX   = 0;
  localparam int UNUSED_INDEX   = 1;
  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Two pipeline stages; allow a little margin after the last result
  localparam int DRAIN_CYCLES   = 4;

  typedef struct {
    logic signed [IN_W-1:0] alpha;
    logic signed [IN_W-1:0] beta;
  } volt_vec_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic signed [IN_W-1:0] volt_alpha = '0;
  logic signed [IN_W-1:0] volt_beta  = '0;
  logic                   out_ready  = 1'b0;
  logic                   psel       = 1'b0;
  logic                   penable    = 1'b0;
  logic                   pwrite     = 1'b0;
  logic [PADDR_W-1:0]     paddr      = '0;
  logic [31:0]            pwdata     = '0;

  logic                   in_ready;
  logic                   out_valid;
  logic [DUTY_W-1:0]      duty_a;
  logic [DUTY_W-1:0]      duty_b;
  logic [DUTY_W-1:0]      duty_c;
  logic [2:0]             sector;
  logic [31:0]            prdata;
  logic                   pready;

  // Vectors waiting to be driven, and compare sets waiting to come out
  volt_vec_t   vec_queue[$];
  svpwm_res_t  compare_expect[$];

  // Mirror of the period register, updated on every APB write to that register
  logic [DUTY_W-1:0] period_cfg = PERIOD_RESET;
  bit                idle_on    = 1'b1;
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       gap_left   = 0;
  int unsigned       stall_left = 0;

  space_vector_pwm_compare dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .volt_alpha (volt_alpha),
    .volt_beta  (volt_beta),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .duty_a     (duty_a),
    .duty_b     (duty_b),
    .duty_c     (duty_c),
    .sector     (sector),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Scale by 1/sqrt(3) in Q24, truncating the magnitude so the result rounds
  // toward zero for either sign.
  function automatic longint scale_by_inv_sqrt3(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * longint'(INV_SQRT3_Q24)) >>> 24;
    return (v < 0) ? -mag : mag;
  endfunction

  // Turn a doubled fixed-point compare into counts: drop the fraction bits and
  // the factor two, then clamp into 0..period.
  function automatic logic [DUTY_W-1:0] compare_in_counts(input longint v2,
                                                          input logic [DUTY_W-1:0] period);
    longint q;
    if (v2 <= 0) return '0;
    q = v2 >>> (FRACTION_BITS + 1);
    if (q > longint'(period)) return period;
    return q[DUTY_W-1:0];
  endfunction

  function automatic svpwm_res_t predict_compare(input logic signed [IN_W-1:0] alpha,
                                                 input logic signed [IN_W-1:0] beta,
                                                 input logic [DUTY_W-1:0] period);
    longint     a, b, m, p2, ta, tb, tc, tx, ty;
    sector_t    sec;
    svpwm_res_t res;
    // Inverted output polarity: work on the negated vector throughout
    a  = -longint'(alpha);
    b  = -longint'(beta);
    m  = scale_by_inv_sqrt3(b);
    p2 = longint'(period) << FRACTION_BITS;

    // Ties fall to the lower-numbered side in the upper half plane and to
    // sectors 5 and 6 in the lower half, as the comparisons below are strict
    if (b >= 0) begin
      if (a >= 0) sec = (m > a) ? SECTOR_2 : SECTOR_1;
      else        sec = (-m > a) ? SECTOR_3 : SECTOR_2;
    end else if (a >= 0) begin
      sec = (-m > a) ? SECTOR_5 : SECTOR_6;
    end else begin
      sec = (m > a) ? SECTOR_4 : SECTOR_5;
    end

    // All compares are held doubled, so the half factor stays exact
    case (sec)
      SECTOR_1: begin
        tx = a - m;  ty = 2 * m;
        ta = p2 - tx - ty; tb = ta + 2 * tx; tc = tb + 2 * ty;
      end
      SECTOR_2: begin
        tx = a + m;  ty = -a + m;
        tb = p2 - tx - ty; ta = tb + 2 * ty; tc = ta + 2 * tx;
      end
      SECTOR_3: begin
        tx = 2 * m;  ty = -a - m;
        tb = p2 - tx - ty; tc = tb + 2 * tx; ta = tc + 2 * ty;
      end
      SECTOR_4: begin
        tx = -a + m; ty = -2 * m;
        tc = p2 - tx - ty; tb = tc + 2 * ty; ta = tb + 2 * tx;
      end
      SECTOR_5: begin
        tx = -a - m; ty = a - m;
        tc = p2 - tx - ty; ta = tc + 2 * tx; tb = ta + 2 * ty;
      end
      default: begin
        tx = -2 * m; ty = a + m;
        ta = p2 - tx - ty; tc = ta + 2 * ty; tb = tc + 2 * tx;
      end
    endcase

    res.duty_a = compare_in_counts(ta, period);
    res.duty_b = compare_in_counts(tb, period);
    res.duty_c = compare_in_counts(tc, period);
    res.sector = sec;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: mirror register writes, predict on every accepted vector, check
  // every accepted result, and watch for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    svpwm_res_t want;
    bit         moved;
    if (!rst) begin
      moved = 1'b0;
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        if ((paddr >> 2) == PERIOD_INDEX) period_cfg = pwdata[DUTY_W-1:0];
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        compare_expect.push_back(predict_compare(volt_alpha, volt_beta, period_cfg));
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (compare_expect.size() == 0) begin
          $error("unexpected result: duty_a %0d duty_b %0d duty_c %0d sector %0d",
                 duty_a, duty_b, duty_c, sector);
          mismatches++;
        end else begin
          want = compare_expect.pop_front();
          check_field("duty_a", want.duty_a, duty_a);
          check_field("duty_b", want.duty_b, duty_b);
          check_field("duty_c", want.duty_c, duty_c);
          check_field("sector", int'(want.sector), sector);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next vector once the previous transaction is taken;
  // drop valid only in a random idle burst or when nothing is pending.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    volt_vec_t next_vec;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        // Start an idle burst: this cycle, then gap_left more drawn at random
        gap_left <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (vec_queue.size() != 0) begin
        next_vec   = vec_queue.pop_front();
        volt_alpha <= next_vec.alpha;
        volt_beta  <= next_vec.beta;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stall bursts, this cycle plus stall_left more
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue a vector given in negated terms, the frame the sector logic uses
  task automatic push_negated(input longint a, input longint b);
    volt_vec_t v;
    logic [IN_W-1:0] alpha_bits, beta_bits;
    alpha_bits = IN_W'(-a);
    beta_bits  = IN_W'(-b);
    v.alpha    = alpha_bits;
    v.beta     = beta_bits;
    vec_queue.push_back(v);
  endtask

  function automatic longint rand_within(input longint reach);
    return longint'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic longint rand_full24();
    logic [31:0] r;
    r = $urandom();
    return longint'($signed(r[IN_W-1:0]));
  endfunction

  // APB write with a setup and an access phase; return at the falling edge after
  // the write so the register mirror is settled
  task automatic write_register(input int index, input logic [31:0] word);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(index * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every queued vector has gone in and every result has come out
  task automatic settle();
    do @(negedge clk);
    while (vec_queue.size() != 0 || in_valid || compare_expect.size() != 0);
  endtask

  // Exact sector boundaries: alpha equal to +-beta/sqrt(3) in all quadrants
  task automatic push_ties(input longint mag);
    longint m;
    m = scale_by_inv_sqrt3(mag);
    push_negated(m, mag);
    push_negated(-m, mag);
    push_negated(m, -mag);
    push_negated(-m, -mag);
  endtask

  task automatic queue_directed();
    // Zero, smallest steps and the full-scale corners
    push_negated(0, 0);
    push_negated(1, 0);
    push_negated(-1, 0);
    push_negated(0, 1);
    push_negated(0, -1);
    push_negated(-8388607, -8388607);
    push_negated(8388608, 8388608);
    push_negated(-8388607, 8388608);
    push_negated(8388608, -8388607);
    push_negated(-8388607, 0);
    push_negated(8388608, 0);
    push_negated(0, -8388607);
    push_negated(0, 8388608);
    // One vector in the middle of each sector, inside the hexagon
    push_negated(346410, 200000);
    push_negated(0, 400000);
    push_negated(-346410, 200000);
    push_negated(-346410, -200000);
    push_negated(0, -400000);
    push_negated(346410, -200000);
    push_ties(500000);
  endtask

  // Mostly vectors sized to the current period, with full-range noise,
  // boundary ties, tiny values and corners mixed in
  task automatic queue_random_phase(input int unsigned count);
    int unsigned pick;
    longint      reach, a, b, m;
    reach = (longint'(period_cfg) << FRACTION_BITS) * 3 / 5;
    if (reach < 16) reach = 16;
    if (reach > 8388607) reach = 8388607;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_negated(rand_within(reach), rand_within(reach));
      end else if (pick < 75) begin
        a = rand_full24();
        b = rand_full24();
        vec_queue.push_back('{alpha: IN_W'(a), beta: IN_W'(b)});
      end else if (pick < 85) begin
        b = longint'($urandom_range(0, reach));
        if ($urandom_range(0, 1)) b = -b;
        m = scale_by_inv_sqrt3(b);
        a = ($urandom_range(0, 1) ? m : -m) + longint'($urandom_range(0, 2)) - 1;
        push_negated(a, b);
      end else if (pick < 93) begin
        push_negated(rand_within(4), rand_within(4));
      end else begin
        case ($urandom_range(0, 3))
          0: a = 8388607;
          1: a = -8388607;
          2: a = reach;
          default: a = 0;
        endcase
        case ($urandom_range(0, 3))
          0: b = 8388607;
          1: b = -8388607;
          2: b = -reach;
          default: b = 0;
        endcase
        push_negated(a, b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] word;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Period from reset: directed vectors first, then random ones
    queue_directed();
    queue_random_phase(90);
    settle();

    // Zero period clamps everything to zero; a period of one leaves 0 or 1
    write_register(PERIOD_INDEX, 32'd0);
    queue_random_phase(50);
    settle();
    write_register(PERIOD_INDEX, 32'd1);
    queue_random_phase(50);
    settle();

    // Largest period: the hexagon outgrows the input range
    write_register(PERIOD_INDEX, 32'h0000_FFFF);
    queue_random_phase(100);
    settle();

    // A write to an unmapped register must leave the period alone
    write_register(UNUSED_INDEX, $urandom());
    queue_random_phase(40);
    settle();

    // A stretch with no idling at all, then random periods with junk above
    // the sixteen register bits
    idle_on = 1'b0;
    write_register(PERIOD_INDEX, 32'($urandom_range(2, 65534)));
    queue_random_phase(80);
    settle();
    idle_on = 1'b1;
    repeat (2) begin
      word = $urandom();
      word[DUTY_W-1:0] = DUTY_W'($urandom_range(2, 65534));
      write_register(PERIOD_INDEX, word);
      queue_random_phase(100);
      settle();
    end

    // Closing part at full rate on both sides, back on the reset period
    idle_on = 1'b0;
    write_register(PERIOD_INDEX, 32'(PERIOD_RESET));
    queue_random_phase(90);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && compare_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: space_vector_pwm_compare.f
+incdir+src
src/svpwm_pkg.sv
src/svpwm_scale.sv
src/svpwm_dwell.sv
src/space_vector_pwm_compare.sv
sim/tb_space_vector_pwm_compare.sv
